FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; pulled in with `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/tdsc_pkg.sv
// types and constants for the tftp data sender control block
// no dependencies; imported by tdsc_step and tftp_data_sender_control
`default_nettype none

package tdsc_pkg;

    localparam int RETRY_W = 4;
    localparam int PORT_W  = 16;
    localparam int BLOCK_W = 16;

    localparam logic [15:0] ACK_OPCODE = 16'd4;
    localparam logic [15:0] ACK_LENGTH = 16'd4;

    // configuration register indexes
    localparam logic [0:0] CFG_RETRY_LIMIT = 1'b0;
    localparam logic [0:0] CFG_PEER_PORT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_NEW_TRANSFER = 2'd0,
        CMD_NEXT_BLOCK   = 2'd1,
        CMD_TIMEOUT      = 2'd2,
        CMD_PACKET       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_SEND_DATA    = 2'd0,
        ACT_SEND_ERROR   = 2'd1,
        ACT_REQUEST_NEXT = 2'd2,
        ACT_COMPLETE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ERR_RETRY_ABORT = 2'd0,
        ERR_ILLEGAL_OP  = 2'd1,
        ERR_UNKNOWN_TID = 2'd2
    } t_err_kind;

    typedef struct packed {
        t_action   action;
        t_err_kind error_kind;
        logic      last;
    } t_res_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/tdsc_step.sv
// transfer state and per-command decision logic of the tftp data sender
// depends on tdsc_pkg
`default_nettype none

module tdsc_step #(
    parameter int BLOCK_BYTES = 512,
    parameter int LEN_W       = 10
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic [tdsc_pkg::RETRY_W-1:0]              i_retry_limit,
    input  wire logic [tdsc_pkg::PORT_W-1:0]               i_peer_port,
    input  wire logic                                      i_fire,
    input  wire tdsc_pkg::t_cmd                            i_cmd,
    input  wire logic [LEN_W-1:0]                          i_block_length,
    input  wire logic [15:0]                               i_source_port,
    input  wire logic [15:0]                               i_packet_length,
    input  wire logic [15:0]                               i_packet_opcode,
    input  wire logic [15:0]                               i_packet_block,
    output logic [1:0]                                     o_count,
    output tdsc_pkg::t_res_ctl [1:0]                       o_ctl,
    output logic [1:0][tdsc_pkg::BLOCK_W-1:0]              o_block_number,
    output logic [1:0][LEN_W-1:0]                          o_data_length
);
    import tdsc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_AWAIT = 2'd1,
        PH_NEED  = 2'd2
    } t_phase;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(BLOCK_BYTES);

    t_phase               r_phase, n_phase;
    logic [BLOCK_W-1:0]   r_acked, n_acked;
    logic [RETRY_W-1:0]   r_retry, n_retry;
    logic [LEN_W-1:0]     r_len, n_len;

    logic [BLOCK_W-1:0]   w_next_blk;
    logic [RETRY_W-1:0]   w_retry_inc;
    logic [LEN_W-1:0]     w_sat_len;

    assign w_next_blk  = r_acked + BLOCK_W'(1);
    assign w_retry_inc = r_retry + RETRY_W'(1);
    assign w_sat_len   = (i_block_length > MAX_LEN) ? MAX_LEN : i_block_length;

    always_comb begin
        n_phase        = r_phase;
        n_acked        = r_acked;
        n_retry        = r_retry;
        n_len          = r_len;
        o_count        = 2'd0;
        o_ctl          = '{default: '{ACT_SEND_DATA, ERR_RETRY_ABORT, 1'b0}};
        o_block_number = '0;
        o_data_length  = '0;

        case (i_cmd)
            CMD_NEW_TRANSFER: begin
                n_acked  = '0;
                n_retry  = '0;
                n_len    = '0;
                n_phase  = PH_NEED;
                o_count  = 2'd1;
                o_ctl[0] = '{ACT_REQUEST_NEXT, ERR_RETRY_ABORT, 1'b1};
            end
            CMD_NEXT_BLOCK: begin
                if (r_phase == PH_NEED) begin
                    n_len             = w_sat_len;
                    n_retry           = '0;
                    n_phase           = PH_AWAIT;
                    o_count           = 2'd1;
                    o_ctl[0]          = '{ACT_SEND_DATA, ERR_RETRY_ABORT, 1'b1};
                    o_block_number[0] = w_next_blk;
                    o_data_length[0]  = w_sat_len;
                end
            end
            CMD_TIMEOUT: begin
                if (r_phase == PH_AWAIT) begin
                    n_retry           = w_retry_inc;
                    o_block_number[0] = w_next_blk;
                    o_data_length[0]  = r_len;
                    // a limit of zero aborts on the first timeout as well
                    if (w_retry_inc >= i_retry_limit) begin
                        n_phase  = PH_IDLE;
                        o_count  = 2'd2;
                        o_ctl[0] = '{ACT_SEND_DATA, ERR_RETRY_ABORT, 1'b0};
                        o_ctl[1] = '{ACT_SEND_ERROR, ERR_RETRY_ABORT, 1'b1};
                    end else begin
                        o_count  = 2'd1;
                        o_ctl[0] = '{ACT_SEND_DATA, ERR_RETRY_ABORT, 1'b1};
                    end
                end
            end
            CMD_PACKET: begin
                if (r_phase == PH_AWAIT) begin
                    if (i_source_port != i_peer_port) begin
                        o_count  = 2'd1;
                        o_ctl[0] = '{ACT_SEND_ERROR, ERR_UNKNOWN_TID, 1'b1};
                    end else if (i_packet_length != ACK_LENGTH ||
                                 i_packet_opcode != ACK_OPCODE) begin
                        o_count  = 2'd1;
                        o_ctl[0] = '{ACT_SEND_ERROR, ERR_ILLEGAL_OP, 1'b1};
                    end else if (i_packet_block == w_next_blk) begin
                        n_acked = w_next_blk;
                        o_count = 2'd1;
                        // a full block means more data follows
                        if (r_len == MAX_LEN) begin
                            n_phase  = PH_NEED;
                            o_ctl[0] = '{ACT_REQUEST_NEXT, ERR_RETRY_ABORT, 1'b1};
                        end else begin
                            n_phase  = PH_IDLE;
                            o_ctl[0] = '{ACT_COMPLETE, ERR_RETRY_ABORT, 1'b1};
                        end
                    end
                end
            end
            default: begin
                o_count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acked <= '0;
            r_retry <= '0;
            r_len   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acked <= n_acked;
            r_retry <= n_retry;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tftp_data_sender_control.sv
// top level of the tftp data sender control: input register, step logic, result queue
// depends on tdsc_pkg, tdsc_step and assert_macros.svh
//
//  channel   | direction | handshake           | contents
//  ----------+-----------+---------------------+--------------------------------------
//  s (cmd)   | in        | i_s_tvalid/o_s_tready| tuser command, tdata packet fields
//  m (result)| out       | o_m_tvalid/i_m_tready| tuser action, tdata block/len/err, tlast
//  cfg       | in        | i_cfg_we            | index 0 retry_limit, 1 peer_port
//
// one item per cycle: an item is registered, decided from that register and its results
// land in a two-entry result queue; the queue's free space sets when the input stage moves.
// a timeout that aborts gives two results and waits for an empty queue; a later item that
// gives a result then waits until the head of the queue is popped.
// reset is synchronous, active low, and clears the transfer state and both handshake stages.
// a stall on the result side backs up into o_s_tready through the queue fill only.
`default_nettype none
`include "assert_macros.svh"

module tftp_data_sender_control #(
    parameter int  BLOCK_BYTES = 512,
    localparam int LEN_W       = $clog2(BLOCK_BYTES + 1),
    localparam int IN_W        = ((LEN_W + 64 + 7) / 8) * 8,
    localparam int OUT_W       = ((LEN_W + 18 + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [0:0]                        i_cfg_index,
    input  wire logic [tdsc_pkg::PORT_W-1:0]       i_cfg_data,
    // command items
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // block_length, source_port, packet_length, packet_opcode, packet_block, zero fill
    input  wire logic [IN_W-1:0]                   i_s_tdata,
    // command
    input  wire logic [1:0]                        i_s_tuser,
    // result items
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // block_number, data_length, error_kind, zero fill
    output logic [OUT_W-1:0]                       o_m_tdata,
    // action
    output logic [1:0]                             o_m_tuser,
    output logic                                   o_m_tlast
);
    import tdsc_pkg::*;

    localparam int SP_LO = LEN_W;
    localparam int PL_LO = LEN_W + 16;
    localparam int PO_LO = LEN_W + 32;
    localparam int PB_LO = LEN_W + 48;

    // configuration registers
    logic [RETRY_W-1:0] r_retry_limit;
    logic [PORT_W-1:0]  r_peer_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_W'(3);
            r_peer_port   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[RETRY_W-1:0];
                CFG_PEER_PORT:   r_peer_port   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    logic               r_in_valid;
    t_cmd               r_cmd;
    logic [LEN_W-1:0]   r_blen;
    logic [15:0]        r_sport, r_plen, r_popc, r_pblk;

    // result queue, entry 0 is the head
    logic [1:0]                   r_q_cnt, n_q_cnt;
    t_res_ctl [1:0]               r_q_ctl, n_q_ctl;
    logic [1:0][BLOCK_W-1:0]      r_q_bn, n_q_bn;
    logic [1:0][LEN_W-1:0]        r_q_len, n_q_len;

    logic [1:0]                   w_res_cnt;
    t_res_ctl [1:0]               w_res_ctl;
    logic [1:0][BLOCK_W-1:0]      w_res_bn;
    logic [1:0][LEN_W-1:0]        w_res_len;
    logic                         w_fire;
    logic                         w_pop;
    logic [1:0]                   w_free;

    // room is judged without the pop so i_m_tready never reaches o_s_tready
    assign w_free     = 2'd2 - r_q_cnt;
    assign w_fire     = r_in_valid && (w_res_cnt <= w_free);
    assign o_s_tready = !r_in_valid || w_fire;
    assign w_pop      = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_cmd   <= t_cmd'(i_s_tuser);
            r_blen  <= i_s_tdata[LEN_W-1:0];
            r_sport <= i_s_tdata[SP_LO +: 16];
            r_plen  <= i_s_tdata[PL_LO +: 16];
            r_popc  <= i_s_tdata[PO_LO +: 16];
            r_pblk  <= i_s_tdata[PB_LO +: 16];
        end
    end

    tdsc_step #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .LEN_W       (LEN_W)
    ) u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_retry_limit   (r_retry_limit),
        .i_peer_port     (r_peer_port),
        .i_fire          (w_fire),
        .i_cmd           (r_cmd),
        .i_block_length  (r_blen),
        .i_source_port   (r_sport),
        .i_packet_length (r_plen),
        .i_packet_opcode (r_popc),
        .i_packet_block  (r_pblk),
        .o_count         (w_res_cnt),
        .o_ctl           (w_res_ctl),
        .o_block_number  (w_res_bn),
        .o_data_length   (w_res_len)
    );

    always_comb begin
        n_q_cnt = r_q_cnt;
        n_q_ctl = r_q_ctl;
        n_q_bn  = r_q_bn;
        n_q_len = r_q_len;
        if (w_pop) begin
            n_q_ctl[0] = r_q_ctl[1];
            n_q_bn[0]  = r_q_bn[1];
            n_q_len[0] = r_q_len[1];
            n_q_cnt    = r_q_cnt - 2'd1;
        end
        if (w_fire && w_res_cnt != 2'd0) begin
            // append after whatever is left; two results only arrive into an empty queue
            n_q_ctl[n_q_cnt[0]] = w_res_ctl[0];
            n_q_bn[n_q_cnt[0]]  = w_res_bn[0];
            n_q_len[n_q_cnt[0]] = w_res_len[0];
            if (w_res_cnt == 2'd2) begin
                n_q_ctl[1] = w_res_ctl[1];
                n_q_bn[1]  = w_res_bn[1];
                n_q_len[1] = w_res_len[1];
            end
            n_q_cnt = n_q_cnt + w_res_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_ctl <= n_q_ctl;
        r_q_bn  <= n_q_bn;
        r_q_len <= n_q_len;
    end

    assign o_m_tvalid = (r_q_cnt != 2'd0);
    assign o_m_tuser  = r_q_ctl[0].action;
    assign o_m_tlast  = r_q_ctl[0].last;
    assign o_m_tdata  = OUT_W'({r_q_ctl[0].error_kind, r_q_len[0], r_q_bn[0]});

    // checks
    logic [2:0] w_cnt_expect;
    assign w_cnt_expect = 3'(r_q_cnt) + (w_fire ? 3'(w_res_cnt) : 3'd0) - 3'(w_pop);

    `ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, w_fire && (3'(r_q_cnt) + 3'(w_res_cnt) > 3'd2), "result queue overflow")
    `ASSERT_ALWAYS(a_q_count, i_clk, i_rst_n, $past(i_rst_n) |-> (3'(r_q_cnt) == $past(w_cnt_expect)), "result queue count mismatch")
    `ASSERT_ALWAYS(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_fire) |=> r_in_valid, "input stage dropped an item")

endmodule

`default_nettype wire
